@@ design/krd_pkg.sv @@
package krd_pkg;

   // phase codes: 0 to 16 are the field kinds, then the two idle phases
   localparam logic [4:0] PH_DONE = 5'd17;
   localparam logic [4:0] PH_TYPE = 5'd18;

   // field kinds with a meaning of their own
   localparam logic [4:0] KIND_END = 5'd17;

   // end status codes
   localparam logic [1:0] ST_COMPLETE  = 2'd0;
   localparam logic [1:0] ST_WRONG     = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;

   localparam logic [7:0] TYPE_RESET = 8'h0a;

   typedef struct packed {
      logic [4:0]  field_kind;
      logic [31:0] field_value;
      logic [1:0]  status;
      logic        last_of_run;
   } result_type;

   // kinds that carry a 4-byte length
   function automatic logic is_length_kind(input logic [4:0] k);
      return (k == 5'd3) || (k == 5'd6) || (k == 5'd8) ||
             (k == 5'd11) || (k == 5'd13) || (k == 5'd15);
   endfunction

   // kinds whose bytes are passed on one by one
   function automatic logic is_payload_kind(input logic [4:0] k);
      return (k == 5'd4) || (k == 5'd7) || (k == 5'd9) ||
             (k == 5'd12) || (k == 5'd14) || (k == 5'd16);
   endfunction

endpackage

@@ design/krd_if.sv @@
// packet byte channel
interface krd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_packet;
   modport source (output valid, output in_byte, output end_of_packet, input ready);
   modport sink (input valid, input in_byte, input end_of_packet, output ready);
endinterface

// result channel
interface krd_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  field_kind;
   logic [31:0] field_value;
   logic [1:0]  status;
   logic        last_of_run;
   modport source (output valid, output field_kind, output field_value, output status,
                   output last_of_run, input ready);
   modport sink (input valid, input field_kind, input field_value, input status,
                 input last_of_run, output ready);
endinterface

// register write channel
interface krd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/key_reply_deframer.sv @@
// channel   direction  payload
// req_bus   in         in_byte[7:0], end_of_packet
// rsp_bus   out        field_kind[4:0], field_value[31:0], status[1:0], last_of_run
// csr_bus   in         data[7:0] -> expected_type
//
// One packet byte is taken per cycle while req_bus.ready is high. The frame
// state is updated in the cycle of the transfer and its results land in a
// three-entry result buffer. A byte that ends a word and the packet at once
// gives two results, which enter the buffer together and hold off the byte input.
// Reset is synchronous: frame state back to the type phase, expected_type to 10.
// req_bus.ready is decoded from the registered count: high while at most one result waits.
module key_reply_deframer
   import krd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   krd_req_if.sink   req_bus,
   krd_rsp_if.source rsp_bus,
   krd_csr_if.sink   csr_bus
);

   logic [7:0]  type_ff;
   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  biw_ff, biw_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] word_ff, word_in;
   logic        discard_ff, discard_in;
   logic [1:0]  err_ff, err_in;

   result_type  slot_ff [3];
   result_type  slot_in [3];
   logic [1:0]  count_ff, count_in;

   logic        accept;
   logic        drain;
   logic [1:0]  base;
   logic [1:0]  add;
   logic        emit_field;
   result_type  field_res, end_res;
   result_type  first_res, second_res;
   logic [31:0] word_full;

   // register write port
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= TYPE_RESET;
      end else if (csr_bus.valid) begin
         type_ff <= csr_bus.data;
      end
   end

   // room for two more results behind what waits
   assign req_bus.ready = (count_ff <= 2'd1);
   assign accept = req_bus.valid && req_bus.ready;

   assign word_full = word_ff | ({24'd0, req_bus.in_byte} << {biw_ff, 3'b000});

   // frame state update for one byte
   always_comb begin
      phase_in   = phase_ff;
      biw_in     = biw_ff;
      left_in    = left_ff;
      word_in    = word_ff;
      discard_in = discard_ff;
      err_in     = err_ff;
      emit_field = 1'b0;
      field_res  = '{field_kind: phase_ff, field_value: 32'd0, status: ST_COMPLETE,
                     last_of_run: 1'b0};
      end_res    = '{field_kind: KIND_END, field_value: 32'd0, status: ST_COMPLETE,
                     last_of_run: 1'b1};
      priority if (discard_ff) begin
         // wrong-type packet, drop the byte
      end else if (phase_ff == PH_TYPE) begin
         if (req_bus.in_byte != type_ff) begin
            discard_in = 1'b1;
            err_in     = ST_WRONG;
         end else begin
            phase_in = 5'd0;
            biw_in   = 2'd0;
            word_in  = 32'd0;
         end
      end else if (phase_ff < PH_DONE && is_payload_kind(phase_ff)) begin
         emit_field            = 1'b1;
         field_res.field_value = {24'd0, req_bus.in_byte};
         if (left_ff != 32'd0) begin
            left_in = left_ff - 32'd1;
         end
         if (left_ff <= 32'd1) begin
            phase_in = phase_ff + 5'd1;
         end
      end else if (phase_ff < PH_DONE) begin
         word_in = word_full;
         if (biw_ff == 2'd3) begin
            emit_field            = 1'b1;
            field_res.field_value = word_full;
            word_in               = 32'd0;
            biw_in                = 2'd0;
            if (is_length_kind(phase_ff) && word_full == 32'd0) begin
               phase_in = phase_ff + 5'd2;
            end else begin
               phase_in = phase_ff + 5'd1;
               if (is_length_kind(phase_ff)) begin
                  left_in = word_full;
               end
            end
         end else begin
            biw_in = biw_ff + 2'd1;
         end
      end else begin
         // trailing bytes after the signature
      end

      // end of packet: status and back to the type phase
      if (req_bus.end_of_packet) begin
         if (err_in != 2'd0) begin
            end_res.status = err_in;
         end else begin
            end_res.status = (phase_in == PH_DONE) ? ST_COMPLETE : ST_TRUNCATED;
         end
         phase_in   = PH_TYPE;
         biw_in     = 2'd0;
         left_in    = 32'd0;
         word_in    = 32'd0;
         discard_in = 1'b0;
         err_in     = 2'd0;
      end else begin
         field_res.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         biw_ff     <= 2'd0;
         left_ff    <= 32'd0;
         word_ff    <= 32'd0;
         discard_ff <= 1'b0;
         err_ff     <= 2'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         biw_ff     <= biw_in;
         left_ff    <= left_in;
         word_ff    <= word_in;
         discard_ff <= discard_in;
         err_ff     <= err_in;
      end
   end

   // result buffer: the head drains, new results append behind what stays
   assign drain = (count_ff != 2'd0) && rsp_bus.ready;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      slot_in[2] = slot_ff[2];
      if (drain) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
      base       = count_ff - {1'b0, drain};
      first_res  = emit_field ? field_res : end_res;
      second_res = end_res;
      add        = accept ? ({1'b0, emit_field} + {1'b0, req_bus.end_of_packet}) : 2'd0;
      if (add != 2'd0) begin
         if (base == 2'd0) begin
            slot_in[0] = first_res;
            slot_in[1] = second_res;
         end else begin
            slot_in[1] = first_res;
            slot_in[2] = second_res;
         end
      end
      count_in = base + add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      slot_ff[2] <= slot_in[2];
   end

   assign rsp_bus.valid       = (count_ff != 2'd0);
   assign rsp_bus.field_kind  = slot_ff[0].field_kind;
   assign rsp_bus.field_value = slot_ff[0].field_value;
   assign rsp_bus.status      = slot_ff[0].status;
   assign rsp_bus.last_of_run = slot_ff[0].last_of_run;

   // checks
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_TYPE)
      else $error("phase out of range");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff < PH_DONE && is_payload_kind(phase_ff)) |-> left_ff != 32'd0)
      else $error("payload phase with no bytes left");

   a_wrong_type: assert property (@(posedge clock) disable iff (reset)
      (accept && !discard_ff && phase_ff == PH_TYPE && req_bus.in_byte != type_ff &&
       !req_bus.end_of_packet) |=> discard_ff)
      else $error("wrong type byte did not start discarding");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.field_kind == KIND_END) |-> rsp_bus.last_of_run)
      else $error("end status not marked last");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
   import krd_pkg::*;
();

   // field kinds that steer the frame walk
   localparam logic [4:0] K_SRC_ADDR  = 5'd0;
   localparam logic [4:0] K_KEY_LEN   = 5'd3;
   localparam logic [4:0] K_KEY       = 5'd4;
   localparam logic [4:0] K_REVOC_LEN = 5'd6;
   localparam logic [4:0] K_REVOC     = 5'd7;
   localparam logic [4:0] K_CERT_LEN  = 5'd8;
   localparam logic [4:0] K_CERT      = 5'd9;
   localparam logic [4:0] K_KSIG_LEN  = 5'd11;
   localparam logic [4:0] K_KSIG      = 5'd12;
   localparam logic [4:0] K_BSIG_LEN  = 5'd13;
   localparam logic [4:0] K_BSIG      = 5'd14;
   localparam logic [4:0] K_SIG_LEN   = 5'd15;
   localparam logic [4:0] K_SIG       = 5'd16;
   localparam logic [1:0] NO_STATUS   = 2'd0;

   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 3000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_BYTES   = 250;
   localparam int REPORT_LIMIT  = 10;

   // reply decoder and store of the fields still to come
   class reply_scoreboard;
      logic [4:0]  phase;
      logic [1:0]  byte_in_word;
      logic [31:0] payload_left;
      logic [31:0] word_buffer;
      bit          discarding;
      logic [1:0]  error_seen;
      logic [7:0]  expected_type;
      result_type  pending_fields[$];
      int          mismatches;

      function new();
         expected_type = TYPE_RESET;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = PH_TYPE;
         byte_in_word = '0;
         payload_left = '0;
         word_buffer = '0;
         discarding = 1'b0;
         error_seen = NO_STATUS;
      endfunction

      function bit is_length(logic [4:0] k);
         case (k)
            K_KEY_LEN, K_REVOC_LEN, K_CERT_LEN, K_KSIG_LEN, K_BSIG_LEN, K_SIG_LEN: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function bit is_payload(logic [4:0] k);
         case (k)
            K_KEY, K_REVOC, K_CERT, K_KSIG, K_BSIG, K_SIG: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function result_type field(logic [4:0] k, logic [31:0] v, logic [1:0] st);
         result_type r;
         r.field_kind = k;
         r.field_value = v;
         r.status = st;
         r.last_of_run = 1'b0;
         return r;
      endfunction

      // walk the frame state over one transferred byte
      function void take_byte(logic [7:0] b, logic eop);
         result_type  outs[$];
         logic [31:0] v;
         logic [1:0]  st;
         if (discarding) begin
            // rest of a wrong-type packet is dropped
         end else if (phase == PH_TYPE) begin
            if (b != expected_type) begin
               discarding = 1'b1;
               error_seen = ST_WRONG;
            end else begin
               phase = K_SRC_ADDR;
               byte_in_word = '0;
               word_buffer = '0;
            end
         end else if (phase < PH_DONE && is_payload(phase)) begin
            outs.push_back(field(phase, {24'd0, b}, NO_STATUS));
            if (payload_left > 0) payload_left = payload_left - 32'd1;
            if (payload_left == 0) phase = phase + 5'd1;
         end else if (phase < PH_DONE) begin
            word_buffer = word_buffer | ({24'd0, b} << {byte_in_word, 3'b000});
            if (byte_in_word == 2'd3) begin
               v = word_buffer;
               outs.push_back(field(phase, v, NO_STATUS));
               word_buffer = '0;
               byte_in_word = '0;
               if (is_length(phase)) begin
                  if (v == 0) begin
                     phase = phase + 5'd2;
                  end else begin
                     payload_left = v;
                     phase = phase + 5'd1;
                  end
               end else begin
                  phase = phase + 5'd1;
               end
            end else begin
               byte_in_word = byte_in_word + 2'd1;
            end
         end
         // trailing bytes after the signature fall through untouched

         if (eop) begin
            if (error_seen != NO_STATUS) st = error_seen;
            else st = (phase == PH_DONE) ? ST_COMPLETE : ST_TRUNCATED;
            outs.push_back(field(KIND_END, 32'd0, st));
            clear_frame();
         end
         if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
         foreach (outs[i]) pending_fields.push_back(outs[i]);
      endfunction

      function void check_field(result_type got);
         result_type want;
         if (pending_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected field: kind %0d value %h status %0d last %0b",
                        got.field_kind, got.field_value, got.status, got.last_of_run);
            return;
         end
         want = pending_fields.pop_front();
         if (got.field_kind != want.field_kind || got.field_value !== want.field_value ||
             got.status != want.status || got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("field mismatch: want kind %0d value %h status %0d last %0b",
                        want.field_kind, want.field_value, want.status, want.last_of_run);
               $display("                 got kind %0d value %h status %0d last %0b",
                        got.field_kind, got.field_value, got.status, got.last_of_run);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   krd_req_if req_bus();
   krd_rsp_if rsp_bus();
   krd_csr_if csr_bus();

   key_reply_deframer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   reply_scoreboard sb = new();
   logic [7:0] frame_bytes[$];
   int         burst_left = 0;
   bit         hold_request = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: ready pattern that changes mode now and then, plus a long hold-off
   initial begin
      int mode;
      int seg_left;
      int hold_left;
      int tick;
      mode = 0;
      seg_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (seg_left == 0) begin
            mode = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (tick % 4 != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // result monitor
   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.field_kind = rsp_bus.field_kind;
            got.field_value = rsp_bus.field_value;
            got.status = rsp_bus.status;
            got.last_of_run = rsp_bus.last_of_run;
            sb.check_field(got);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function int next_burst();
      if ($urandom_range(0, 3) == 0) return $urandom_range(100, 300);
      return $urandom_range(1, 30);
   endfunction

   // one byte transfer, with gaps between bursts
   task send_byte(input logic [7:0] b, input logic eop);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = next_burst();
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.end_of_packet <= eop;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_byte(b, eop);
      burst_left--;
   endtask

   task send_frame(inout int sent);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      sent += frame_bytes.size();
   endtask

   // idle the sender until every field has come out
   task wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_type(input logic [7:0] t);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= t;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.expected_type = t;
      repeat (2) @(posedge clock);
   endtask

   // little-endian word, low byte first on the wire
   function void add_word(logic [31:0] w);
      frame_bytes.push_back(w[7:0]);
      frame_bytes.push_back(w[15:8]);
      frame_bytes.push_back(w[23:16]);
      frame_bytes.push_back(w[31:24]);
   endfunction

   function int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function void add_block(int len);
      add_word(len);
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // well-formed reply with random content
   function void build_reply(int key_len);
      frame_bytes.delete();
      frame_bytes.push_back(sb.expected_type);
      repeat (3) add_word($urandom());
      add_block(key_len);
      add_word($urandom());
      add_block(pick_len());
      add_block(pick_len());
      add_word($urandom());
      repeat (3) add_block(pick_len());
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function void build_random_frame();
      int r;
      int keep;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         build_reply(pick_len());
      end else if (r < 75) begin
         // cut short somewhere inside
         build_reply(pick_len());
         keep = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end else if (r < 83) begin
         // wrong type, rest discarded
         frame_bytes.delete();
         frame_bytes.push_back(sb.expected_type ^ 8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 20)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
         // huge key length, packet ends inside the key
         frame_bytes.delete();
         frame_bytes.push_back(sb.expected_type);
         repeat (3) add_word($urandom());
         add_word({1'b1, 31'($urandom())});
         repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // main sequence
   initial begin
      logic [7:0] phase_types[4];
      int sent;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.in_byte <= '0;
      req_bus.end_of_packet <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: type checks, end on the type byte, end with a word, end mid-word
      sent = 0;
      frame_bytes = '{8'h0b};
      send_frame(sent);
      frame_bytes = '{8'h00};
      send_frame(sent);
      frame_bytes = '{TYPE_RESET};
      send_frame(sent);
      frame_bytes = '{8'hff, 8'h00};
      send_frame(sent);
      frame_bytes = '{TYPE_RESET, 8'hff, 8'hff, 8'hff, 8'hff};
      send_frame(sent);
      frame_bytes = '{TYPE_RESET, 8'h00, 8'h12};
      send_frame(sent);
      wait_drained();

      // random phases, each with its own expected type
      phase_types[0] = 8'h00;
      phase_types[1] = 8'hff;
      phase_types[2] = 8'($urandom_range(0, 255));
      phase_types[3] = TYPE_RESET;
      foreach (phase_types[p]) begin
         write_type(phase_types[p]);
         sent = 0;
         if (p == 1) begin
            // result side holds off while long payloads keep coming
            hold_request = 1'b1;
            build_reply(24);
            send_frame(sent);
         end
         while (sent < PHASE_BYTES) begin
            build_random_frame();
            send_frame(sent);
         end
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.pending_fields.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
